[rtl/core/lcdnw_pkg.sv]
// Shared types and constants for the character LCD nibble writer.
package lcdnw_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 10;

    localparam logic [7:0]  SET_ADDR_CMD = 8'h80;
    localparam logic [7:0]  LINE2_BASE   = 8'h40;
    localparam logic [7:0]  CLEAR_CMD    = 8'h01;
    localparam logic [7:0]  ASCII_ZERO   = 8'h30;

    // Divide by ten: q = (v * RECIP10) >> RECIP_SHIFT for any 32-bit v
    localparam logic [31:0] RECIP10      = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT  = 35;
    localparam int unsigned QUOT_W       = 64 - RECIP_SHIFT;

    typedef enum logic [2:0] {
        CMD_CHAR     = 3'd0,
        CMD_CHAR_POS = 3'd1,
        CMD_NUM      = 3'd2,
        CMD_NUM_POS  = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        SRC_ADDR  = 2'd0,
        SRC_CHAR  = 2'd1,
        SRC_DIGIT = 2'd2,
        SRC_CLEAR = 2'd3
    } src_t;

    typedef struct packed {
        logic load_req;
        logic div_mul;
        logic div_upd;
        logic out_load;
        logic out_hi;
        logic out_last;
        src_t src;
        logic rd_dec;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic line_ok;
        logic div_last;
        logic digit_zero;
        logic out_free;
    } ctl_sts_t;

endpackage

[rtl/core/lcdnw_ctrl.sv]
// Sequencing state machine for the character LCD nibble writer.
module lcdnw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcdnw_pkg::ctl_sts_t sts_i,
    output lcdnw_pkg::ctl_cmd_t cmd_o
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_MUL,
        ST_DIV_UPD,
        ST_EMIT_HI,
        ST_EMIT_LO
    } state_t;

    state_t            state_reg, state_next;
    lcdnw_pkg::src_t   src_reg, src_next;

    always_comb begin
        cmd_o      = '0;
        cmd_o.src  = src_reg;
        in_ready   = 1'b0;
        state_next = state_reg;
        src_next   = src_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_o.load_req = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts_i.cmd)
                    lcdnw_pkg::CMD_CHAR: begin
                        src_next   = lcdnw_pkg::SRC_CHAR;
                        state_next = ST_EMIT_HI;
                    end
                    lcdnw_pkg::CMD_CHAR_POS: begin
                        src_next   = sts_i.line_ok ? lcdnw_pkg::SRC_ADDR : lcdnw_pkg::SRC_CHAR;
                        state_next = ST_EMIT_HI;
                    end
                    lcdnw_pkg::CMD_NUM, lcdnw_pkg::CMD_NUM_POS: begin
                        state_next = ST_DIV_MUL;
                    end
                    lcdnw_pkg::CMD_CLEAR: begin
                        src_next   = lcdnw_pkg::SRC_CLEAR;
                        state_next = ST_EMIT_HI;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV_MUL: begin
                cmd_o.div_mul = 1'b1;
                state_next    = ST_DIV_UPD;
            end
            ST_DIV_UPD: begin
                cmd_o.div_upd = 1'b1;
                if (sts_i.div_last) begin
                    src_next   = (sts_i.cmd == lcdnw_pkg::CMD_NUM_POS && sts_i.line_ok)
                               ? lcdnw_pkg::SRC_ADDR : lcdnw_pkg::SRC_DIGIT;
                    state_next = ST_EMIT_HI;
                end else begin
                    state_next = ST_DIV_MUL;
                end
            end
            ST_EMIT_HI: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_hi   = 1'b1;
                    state_next     = ST_EMIT_LO;
                end
            end
            ST_EMIT_LO: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    unique case (src_reg)
                        lcdnw_pkg::SRC_ADDR: begin
                            src_next   = (sts_i.cmd == lcdnw_pkg::CMD_CHAR_POS)
                                       ? lcdnw_pkg::SRC_CHAR : lcdnw_pkg::SRC_DIGIT;
                            state_next = ST_EMIT_HI;
                        end
                        lcdnw_pkg::SRC_DIGIT: begin
                            if (sts_i.digit_zero) begin
                                cmd_o.out_last = 1'b1;
                                state_next     = ST_IDLE;
                            end else begin
                                cmd_o.rd_dec = 1'b1;
                                state_next   = ST_EMIT_HI;
                            end
                        end
                        lcdnw_pkg::SRC_CHAR, lcdnw_pkg::SRC_CLEAR: begin
                            cmd_o.out_last = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            src_reg   <= lcdnw_pkg::SRC_CHAR;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.out_load |-> sts_i.out_free)
        else $error("output register loaded while occupied");
    a_last_is_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.out_last |-> (cmd_o.out_load && !cmd_o.out_hi))
        else $error("final flag on a high nibble");
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");
`endif

endmodule

[rtl/core/lcdnw_datapath.sv]
// Request registers, divide-by-ten unit, digit store and output register.
module lcdnw_datapath #(
    parameter int unsigned MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          s_tuser,
    input  logic [47:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast,
    input  lcdnw_pkg::ctl_cmd_t cmd_i,
    output lcdnw_pkg::ctl_sts_t sts_o
);

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned Q_W   = lcdnw_pkg::QUOT_W;

    lcdnw_pkg::cmd_t    cmd_reg;
    logic [1:0]         line_reg;
    logic [5:0]         column_reg;
    logic [7:0]         char_reg;
    logic [31:0]        value_reg;
    logic [Q_W-1:0]     quot_reg;
    logic [CNT_W-1:0]   dcount_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [3:0]         digit_store [MAX_DIGITS];

    logic               out_valid_reg;
    logic [3:0]         out_nib_reg;
    logic               out_rs_reg;
    logic               out_last_reg;

    logic [63:0]        prod_full;
    logic [3:0]         rem_digit;
    logic [7:0]         addr_byte;
    logic [7:0]         cur_byte;
    logic               cur_rs;

    assign prod_full = {32'b0, value_reg} * {32'b0, lcdnw_pkg::RECIP10};
    assign rem_digit = value_reg[3:0] - ({quot_reg[0], 3'b0} + {quot_reg[2:0], 1'b0});
    assign addr_byte = lcdnw_pkg::SET_ADDR_CMD
                     + (line_reg[0] ? lcdnw_pkg::LINE2_BASE : 8'h00)
                     + {2'b00, column_reg};

    always_comb begin
        unique case (cmd_i.src)
            lcdnw_pkg::SRC_ADDR:  cur_byte = addr_byte;
            lcdnw_pkg::SRC_CHAR:  cur_byte = char_reg;
            lcdnw_pkg::SRC_DIGIT: cur_byte = lcdnw_pkg::ASCII_ZERO + {4'b0, digit_store[rd_idx_reg]};
            lcdnw_pkg::SRC_CLEAR: cur_byte = lcdnw_pkg::CLEAR_CMD;
        endcase
        cur_rs = (cmd_i.src == lcdnw_pkg::SRC_CHAR) || (cmd_i.src == lcdnw_pkg::SRC_DIGIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg     <= '0;
            dcount_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_i.load_req) begin
                value_reg  <= s_tdata[47:16];
                dcount_reg <= '0;
            end
            if (cmd_i.div_upd) begin
                value_reg <= {{(32 - Q_W){1'b0}}, quot_reg};
                if (dcount_reg < CNT_W'(MAX_DIGITS)) begin
                    dcount_reg <= dcount_reg + 1'b1;
                    rd_idx_reg <= dcount_reg[IDX_W-1:0];
                end
            end
            if (cmd_i.rd_dec) begin
                rd_idx_reg <= rd_idx_reg - 1'b1;
            end
            if (cmd_i.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_req) begin
            cmd_reg    <= lcdnw_pkg::cmd_t'(s_tuser);
            line_reg   <= s_tdata[1:0];
            column_reg <= s_tdata[7:2];
            char_reg   <= s_tdata[15:8];
        end
        if (cmd_i.div_mul) begin
            quot_reg <= prod_full[63:lcdnw_pkg::RECIP_SHIFT];
        end
        if (cmd_i.div_upd && dcount_reg < CNT_W'(MAX_DIGITS)) begin
            digit_store[dcount_reg[IDX_W-1:0]] <= rem_digit;
        end
        if (cmd_i.out_load) begin
            out_nib_reg  <= cmd_i.out_hi ? cur_byte[7:4] : cur_byte[3:0];
            out_rs_reg   <= cur_rs;
            out_last_reg <= cmd_i.out_last;
        end
    end

    assign sts_o.cmd        = cmd_reg;
    assign sts_o.line_ok    = ~line_reg[1];
    assign sts_o.div_last   = (quot_reg == '0);
    assign sts_o.digit_zero = (rd_idx_reg == '0);
    assign sts_o.out_free   = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_nib_reg};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcount_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");
    a_read_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcount_reg != '0) |-> ({1'b0, rd_idx_reg} < {1'b0, dcount_reg}))
        else $error("digit read index outside written range");
    a_upd_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.div_upd |-> $past(cmd_i.div_mul))
        else $error("quotient used before it was formed");
`endif

endmodule

[rtl/core/char_lcd_nibble_writer.sv]
// Top level of the character LCD nibble writer.
// Each accepted request is turned into the 4-bit nibble stream of an HD44780-style display,
// high nibble of every byte first; m_tuser is the register-select flag (0 command, 1 data)
// and m_tlast marks the request's final nibble. A request is accepted, then decoded, then
// its nibbles go out one per cycle while the output side keeps taking them. Number requests
// first run a divide-by-ten loop of two steps per decimal digit (a 32 by 32 reciprocal
// multiply, then the digit and quotient update). Unused request codes are accepted and
// produce no items. One request is handled at a time.
module char_lcd_nibble_writer #(
    parameter int unsigned MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // line[1:0], column[7:2], char_code[15:8], number[47:16]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // nibble[3:0], zero[7:4]
    output logic        m_tuser,   // reg_select[0]
    output logic        m_tlast
);

    lcdnw_pkg::ctl_cmd_t ctl_cmd;
    lcdnw_pkg::ctl_sts_t ctl_sts;

    lcdnw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts_i    (ctl_sts),
        .cmd_o    (ctl_cmd)
    );

    lcdnw_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd_i    (ctl_cmd),
        .sts_o    (ctl_sts)
    );

endmodule

[tb/tb_char_lcd_nibble_writer.sv]
// Self-checking testbench for the character LCD nibble writer: requests in, nibbles checked.
module tb_char_lcd_nibble_writer;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam logic [1:0] LINE_TOP      = 2'd0;
    localparam logic [1:0] LINE_BOTTOM   = 2'd1;
    localparam int         RANDOM_REQS   = 330;
    localparam int         DRAIN_CYCLES  = 64;

    typedef struct {
        logic [2:0]  cmd;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [7:0]  code;
        logic [31:0] number;
        int          gap;
    } lcd_req_t;

    typedef struct {
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } lcd_nibble_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_req_t    req_q[$];
    lcd_nibble_t due_nibbles[$];
    lcd_req_t    cur_req;
    int          wait_left   = 0;
    int          stall_left  = 0;
    int          mon_quiet   = 0;
    int          drv_quiet   = 0;
    int          errors      = 0;

    char_lcd_nibble_writer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(string what);
        $display("ERROR %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void push_byte(logic rs, logic [7:0] value);
        lcd_nibble_t n;
        n.rs     = rs;
        n.last   = 1'b0;
        n.nibble = value[7:4];
        due_nibbles.push_back(n);
        n.nibble = value[3:0];
        due_nibbles.push_back(n);
    endfunction

    function automatic void push_address(logic [1:0] line, logic [5:0] column);
        if (line == LINE_TOP) begin
            push_byte(1'b0, lcdnw_pkg::SET_ADDR_CMD + {2'b00, column});
        end else if (line == LINE_BOTTOM) begin
            push_byte(1'b0, lcdnw_pkg::SET_ADDR_CMD + lcdnw_pkg::LINE2_BASE + {2'b00, column});
        end
    endfunction

    function automatic void predict_nibbles(lcd_req_t r);
        logic [3:0]  digits[10];
        logic [31:0] v;
        int          n;
        int          start;
        lcd_nibble_t tail;
        start = due_nibbles.size();
        case (r.cmd)
            lcdnw_pkg::CMD_CHAR: begin
                push_byte(1'b1, r.code);
            end
            lcdnw_pkg::CMD_CHAR_POS: begin
                push_address(r.line, r.column);
                push_byte(1'b1, r.code);
            end
            lcdnw_pkg::CMD_NUM, lcdnw_pkg::CMD_NUM_POS: begin
                if (r.cmd == lcdnw_pkg::CMD_NUM_POS) begin
                    push_address(r.line, r.column);
                end
                v = r.number;
                n = 0;
                do begin
                    digits[n] = 4'(v % 10);
                    n++;
                    v = v / 10;
                end while (v != 0);
                for (int k = n - 1; k >= 0; k--) begin
                    push_byte(1'b1, lcdnw_pkg::ASCII_ZERO + {4'b0000, digits[k]});
                end
            end
            lcdnw_pkg::CMD_CLEAR: begin
                push_byte(1'b0, lcdnw_pkg::CLEAR_CMD);
            end
            default: ;
        endcase
        if (due_nibbles.size() > start) begin
            tail = due_nibbles.pop_back();
            tail.last = 1'b1;
            due_nibbles.push_back(tail);
        end
    endfunction

    function automatic int draw_gap();
        if (drv_quiet != 0) begin
            drv_quiet--;
            return 0;
        end
        if ($urandom_range(15, 0) == 0) begin
            drv_quiet = $urandom_range(30, 8);
        end
        return $urandom_range(12, 0);
    endfunction

    task automatic queue_req(logic [2:0] cmd, logic [1:0] line, logic [5:0] column,
                             logic [7:0] code, logic [31:0] number);
        lcd_req_t r;
        r.cmd    = cmd;
        r.line   = line;
        r.column = column;
        r.code   = code;
        r.number = number;
        r.gap    = draw_gap();
        req_q.push_back(r);
    endtask

    // driver: predict on acceptance, then load the next item after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            wait_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_nibbles(cur_req);
            end
            if (!s_tvalid || s_tready) begin
                if (wait_left != 0) begin
                    s_tvalid  <= 1'b0;
                    wait_left <= wait_left - 1;
                end else if (req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {cur_req.number, cur_req.code, cur_req.column, cur_req.line};
                    s_tuser   <= cur_req.cmd;
                    wait_left <= cur_req.gap;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each item, then hold off for a random stall
    always @(posedge aclk) begin
        lcd_nibble_t e;
        int          stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            if (due_nibbles.size() == 0) begin
                report($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                                 m_tdata, m_tuser, m_tlast));
            end else begin
                e = due_nibbles.pop_front();
                if (m_tdata !== {4'b0000, e.nibble}) begin
                    report($sformatf("tdata %h, want %h", m_tdata, {4'b0000, e.nibble}));
                end
                if (m_tuser !== e.rs) begin
                    report($sformatf("tuser %b, want %b", m_tuser, e.rs));
                end
                if (m_tlast !== e.last) begin
                    report($sformatf("tlast %b, want %b", m_tlast, e.last));
                end
            end
            if (mon_quiet != 0) begin
                mon_quiet = mon_quiet - 1;
                stall = 0;
            end else begin
                stall = $urandom_range(12, 0);
                if ($urandom_range(15, 0) == 0) begin
                    mon_quiet = $urandom_range(40, 10);
                end
            end
            stall_left <= stall;
            m_tready   <= (stall == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int         pick;
        logic [2:0] cmd;
        queue_req(lcdnw_pkg::CMD_CHAR,     2'd3, 6'd63, 8'h00, 32'hFFFF_FFFF);
        queue_req(lcdnw_pkg::CMD_CHAR,     2'd0, 6'd0,  8'hFF, 32'h0000_0000);
        queue_req(lcdnw_pkg::CMD_CHAR_POS, 2'd0, 6'd0,  8'h41, 32'd0);
        queue_req(lcdnw_pkg::CMD_CHAR_POS, 2'd1, 6'd63, 8'h5A, 32'd0);
        queue_req(lcdnw_pkg::CMD_CHAR_POS, 2'd2, 6'd5,  8'h33, 32'd0);
        queue_req(lcdnw_pkg::CMD_CHAR_POS, 2'd3, 6'd0,  8'h7E, 32'd0);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'd0);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'd9);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'd10);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'hFFFF_FFFF);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'd1000000000);
        queue_req(lcdnw_pkg::CMD_NUM_POS,  2'd1, 6'd0,  8'h00, 32'd12345);
        queue_req(lcdnw_pkg::CMD_NUM_POS,  2'd0, 6'd63, 8'h00, 32'd0);
        queue_req(lcdnw_pkg::CMD_NUM_POS,  2'd2, 6'd7,  8'h00, 32'd4000000000);
        queue_req(lcdnw_pkg::CMD_NUM_POS,  2'd3, 6'd63, 8'hFF, 32'hFFFF_FFFF);
        queue_req(lcdnw_pkg::CMD_CLEAR,    2'd0, 6'd0,  8'h00, 32'd0);
        queue_req(CMD_SPARE_LO,            2'd1, 6'd9,  8'h31, 32'd77);
        queue_req(CMD_SPARE_MID,           2'd0, 6'd1,  8'h32, 32'd78);
        queue_req(CMD_SPARE_HI,            2'd3, 6'd2,  8'h33, 32'd79);
        queue_req(lcdnw_pkg::CMD_CHAR,     2'd0, 6'd0,  8'hA5, 32'd0);
        queue_req(lcdnw_pkg::CMD_CHAR,     2'd0, 6'd0,  8'h5A, 32'd0);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'hAAAA_AAAA);
        queue_req(lcdnw_pkg::CMD_NUM,      2'd0, 6'd0,  8'h00, 32'h5555_5555);
        queue_req(lcdnw_pkg::CMD_CLEAR,    2'd3, 6'd63, 8'hFF, 32'hFFFF_FFFF);
        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 5) begin
                cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            end else begin
                cmd = 3'($urandom_range(lcdnw_pkg::CMD_CLEAR, lcdnw_pkg::CMD_CHAR));
            end
            queue_req(cmd, 2'($urandom_range(3, 0)), 6'($urandom_range(63, 0)),
                      8'($urandom_range(255, 0)), $urandom >> $urandom_range(31, 0));
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (req_q.size() != 0 || s_tvalid || due_nibbles.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (due_nibbles.size() != 0) begin
            report($sformatf("%0d expected items never arrived", due_nibbles.size()));
        end
        if (errors == 0) begin
            $display("PASS char_lcd_nibble_writer");
        end else begin
            $display("FAIL char_lcd_nibble_writer");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL char_lcd_nibble_writer");
        $finish;
    end

endmodule

[files.f]
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_ctrl.sv
rtl/core/lcdnw_datapath.sv
rtl/core/char_lcd_nibble_writer.sv
tb/tb_char_lcd_nibble_writer.sv
